>>> rtl/shfr_pkg.sv
package shfr_pkg;

  // Sync header bytes that open every frame.
  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;

  // Frame layout: content starts after header, address, length and command.
  localparam int CONTENT_START = 5;
  localparam int OVERHEAD      = 6;

  // Reset value of the expected command register.
  localparam logic [7:0] EXPECTED_COMMAND_RESET = 8'h36;

  // Result kinds.
  localparam logic KIND_CONTENT = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // One result item.
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [6:0] byte_index;
    logic       checksum_ok;
    logic       command_match;
    logic [7:0] frame_command;
    logic [7:0] frame_address;
    logic [6:0] content_length;
    logic       last;
  } result_t;

endpackage

>>> rtl/shfr_parser.sv
module shfr_parser
  import shfr_pkg::*;
#(
  parameter int FRAME_SIZE = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic [7:0] expected_command,
  output logic       result_valid,
  output result_t    result
);

  localparam int POS_W = $clog2(FRAME_SIZE);
  localparam int LEN_W = $clog2(FRAME_SIZE - OVERHEAD);

  localparam logic [POS_W-1:0] POS_SYNC1   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SYNC2   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_ADDRESS = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LENGTH  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_COMMAND = POS_W'(4);
  localparam logic [8:0]       LEN_LIMIT   = 9'(FRAME_SIZE - OVERHEAD);

  logic [POS_W-1:0] position;
  logic [POS_W-1:0] position_next;
  logic [7:0]       running_sum;
  logic [7:0]       running_sum_next;
  logic [LEN_W-1:0] declared_length;
  logic [LEN_W-1:0] declared_length_next;
  logic [7:0]       held_command;
  logic [7:0]       held_command_next;
  logic [7:0]       held_address;
  logic [7:0]       held_address_next;
  logic [POS_W-1:0] end_position;
  logic [POS_W-1:0] content_offset;

  assign end_position   = POS_W'(declared_length) + POS_W'(CONTENT_START);
  assign content_offset = position - POS_W'(CONTENT_START);

  // Parse one byte: next state and the result it causes, if any.
  always_comb begin
    position_next        = position;
    running_sum_next     = running_sum;
    declared_length_next = declared_length;
    held_command_next    = held_command;
    held_address_next    = held_address;
    result_valid         = 1'b0;

    result.kind           = KIND_CONTENT;
    result.data_byte      = rx_byte;
    result.byte_index     = 7'(content_offset);
    result.checksum_ok    = 1'b0;
    result.command_match  = 1'b0;
    result.frame_command  = held_command;
    result.frame_address  = held_address;
    result.content_length = 7'(declared_length);
    result.last           = 1'b0;

    if (position == POS_SYNC1) begin
      if (rx_byte == SYNC_FIRST) begin
        running_sum_next = SYNC_FIRST;
        position_next    = POS_SYNC2;
      end
    end else if (position == POS_SYNC2) begin
      if (rx_byte != SYNC_SECOND) begin
        position_next = POS_SYNC1;
      end else begin
        running_sum_next = running_sum + rx_byte;
        position_next    = POS_ADDRESS;
      end
    end else if (position == POS_ADDRESS) begin
      held_address_next = rx_byte;
      running_sum_next  = running_sum + rx_byte;
      position_next     = POS_LENGTH;
    end else if (position == POS_LENGTH) begin
      if ({1'b0, rx_byte} >= LEN_LIMIT) begin
        position_next = POS_SYNC1;
      end else begin
        declared_length_next = LEN_W'(rx_byte);
        running_sum_next     = running_sum + rx_byte;
        position_next        = POS_COMMAND;
      end
    end else if (position == end_position) begin
      // Checksum byte closes the frame.
      position_next        = POS_SYNC1;
      result_valid         = 1'b1;
      result.kind          = KIND_END;
      result.data_byte     = 8'd0;
      result.byte_index    = 7'd0;
      result.checksum_ok   = (running_sum == rx_byte);
      result.command_match = (held_command == expected_command);
      result.last          = 1'b1;
    end else begin
      running_sum_next = running_sum + rx_byte;
      position_next    = position + POS_W'(1);
      if (position == POS_COMMAND) begin
        held_command_next = rx_byte;
      end else begin
        result_valid = 1'b1;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= POS_SYNC1;
      running_sum     <= 8'd0;
      declared_length <= '0;
      held_command    <= 8'd0;
      held_address    <= 8'd0;
    end else if (accept) begin
      position        <= position_next;
      running_sum     <= running_sum_next;
      declared_length <= declared_length_next;
      held_command    <= held_command_next;
      held_address    <= held_address_next;
    end
  end

  // The position never runs past the checksum byte of the declared frame.
  assert property (@(posedge clk) disable iff (rst)
    position <= end_position)
    else $error("frame position beyond checksum byte");

  // A wrong first header byte keeps the parser at the first position.
  assert property (@(posedge clk) disable iff (rst)
    accept && position == POS_SYNC1 && rx_byte != SYNC_FIRST |=> position == POS_SYNC1)
    else $error("parser left first header position on a bad byte");

  // Header, address, length and command bytes never produce a result.
  assert property (@(posedge clk) disable iff (rst)
    position <= POS_COMMAND |-> !result_valid)
    else $error("result produced from a header byte");

endmodule

>>> rtl/sync_header_frame_receiver_unit.sv
// A result appears on the master side in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the single output register is refilled in the
// same cycle it is drained, so the input stalls only while a result waits unread.
// Reset (rst, synchronous, active high) returns the parser to the first header
// position, clears the sum and held fields, and sets expected_command to 0x36.
module sync_header_frame_receiver_unit
  import shfr_pkg::*;
#(
  parameter int FRAME_SIZE = 128
) (
  input  logic        clk,
  input  logic        rst,
  // Input byte stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] data_byte, [14:8] byte_index, [15] checksum_ok,
                                 // [16] command_match, [24:17] frame_command,
                                 // [32:25] frame_address, [39:33] content_length
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast,
  // Expected command register write.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic       accept;
  logic       result_valid;
  result_t    result;
  logic [7:0] expected_command;
  result_t    out_result;

  // Take a new request whenever the output register is empty or being drained.
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_command <= EXPECTED_COMMAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      expected_command <= cfg_data;
    end
  end

  shfr_parser #(
    .FRAME_SIZE(FRAME_SIZE)
  ) u_parser (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .rx_byte          (s_tdata),
    .expected_command (expected_command),
    .result_valid     (result_valid),
    .result           (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= accept && result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && result_valid) begin
      out_result <= result;
    end
  end

  assign m_tdata = {out_result.content_length, out_result.frame_address,
                    out_result.frame_command, out_result.command_match,
                    out_result.checksum_ok, out_result.byte_index,
                    out_result.data_byte};
  assign m_tuser = out_result.kind;
  assign m_tlast = out_result.last;

  // The last flag marks exactly the frame end results.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == KIND_END)))
    else $error("last flag disagrees with result kind");

  // Content results carry no verdict bits.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_CONTENT |-> !m_tdata[15] && !m_tdata[16])
    else $error("verdict bits set on a content result");

  // Frame end results carry a zero data byte and index.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_END |-> m_tdata[14:0] == 15'd0)
    else $error("frame end result with nonzero data or index");

endmodule
